FILE: rtl/pfre_pkg.sv
// Package: shared types and constants for the page frame replacement engine.
package pfre_pkg;
  localparam int unsigned PageBits  = 5;
  localparam int unsigned TimeBits  = 16;
  localparam int unsigned FrameOutBits = 7;
  localparam int unsigned CountOutBits = 8;
  localparam logic [TimeBits-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_LRU  = 2'd1,
    POL_LFU  = 2'd2,
    POL_MFU  = 2'd3
  } policy_e;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;
  localparam logic OP_REF     = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
endpackage

FILE: rtl/pfre_ram.sv
// Generic single-port RAM with registered read.
module pfre_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/page_frame_replacement_engine.sv
// Top level: frame table scan engine for page replacement.
// A reference passes through the scan state (RAM read pipelined over the first lim
// entries), a drain state, an update state writing the hit or filled entry and an output
// state that waits while an earlier result is not taken; a release skips the update state.
// One item at a time, set by the single RAM port sweeping the frame table. Result register
// lets the next item be accepted while a result waits. Reset clears valid bits (flip-flops)
// and restores policy 3 and frames_in_use 100; RAM needs no clearing.
module page_frame_replacement_engine
  import pfre_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 128,
  parameter int unsigned PID_BITS   = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [7:0]              cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    opcode_i,
  input  logic [PID_BITS-1:0]     process_id_i,
  input  logic [PageBits-1:0]     page_number_i,
  input  logic [TimeBits-1:0]     tick_time_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic [FrameOutBits-1:0] frame_o,
  output logic                    evicted_o,
  output logic [PageBits-1:0]     victim_page_o,
  output logic                    no_victim_o,
  output logic [CountOutBits-1:0] freed_count_o
);
  localparam int unsigned AW = $clog2(MAX_FRAMES);
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned EW = PID_BITS + PageBits + 3 * TimeBits;

  typedef struct packed {
    logic [PID_BITS-1:0] owner;
    logic [PageBits-1:0] page;
    logic [TimeBits-1:0] load;
    logic [TimeBits-1:0] last;
    logic [TimeBits-1:0] cnt;
  } entry_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_UPD, S_OUT} state_e;

  state_e state_q;
  logic [MAX_FRAMES-1:0] valid_q;
  policy_e policy_q;
  logic [7:0] frames_q;
  logic op_q;
  logic [PID_BITS-1:0] pid_q;
  logic [PageBits-1:0] pg_q;
  logic [TimeBits-1:0] t_q;
  logic [CW-1:0] lim_q, idx_q;
  logic [AW-1:0] rd_q;
  logic rd_v_q;
  logic found_q, free_q, vic_q;
  logic [AW-1:0] hf_q, ff_q, vf_q;
  entry_t hit_e_q, vic_e_q;
  logic [CW-1:0] freed_q;
  logic ov_q;
  logic o_hit_q, o_ev_q, o_nv_q;
  logic [FrameOutBits-1:0] o_fr_q;
  logic [PageBits-1:0] o_vp_q;
  logic [CountOutBits-1:0] o_fc_q;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  entry_t ram_wd, ram_rd;
  logic [EW-1:0] ram_rd_raw;

  pfre_ram #(.Width(EW), .Depth(MAX_FRAMES)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd_raw)
  );
  assign ram_rd = entry_t'(ram_rd_raw);

  logic [CW-1:0] lim_d;
  always_comb begin
    if (32'(frames_q) > 32'(MAX_FRAMES)) lim_d = CW'(MAX_FRAMES);
    else lim_d = CW'(frames_q);
  end

  logic better;
  always_comb begin
    unique case (policy_q)
      POL_FIFO: better = ram_rd.load < vic_e_q.load;
      POL_LRU:  better = ram_rd.last < vic_e_q.last;
      POL_LFU:  better = ram_rd.cnt < vic_e_q.cnt;
      default:  better = ram_rd.cnt > vic_e_q.cnt;
    endcase
  end

  logic upd_hit;
  logic [AW-1:0] fill_f;
  always_comb begin
    upd_hit = found_q;
    fill_f  = free_q ? ff_q : vf_q;
    ram_we  = 1'b0;
    ram_addr = idx_q[AW-1:0];
    ram_wd  = hit_e_q;
    if (state_q == S_UPD) begin
      if (found_q) begin
        ram_we = 1'b1;
        ram_addr = hf_q;
        ram_wd.last = t_q;
        if (hit_e_q.cnt != CountMax) ram_wd.cnt = hit_e_q.cnt + 1'b1;
      end else begin
        ram_we = free_q || vic_q;
        ram_addr = fill_f;
        ram_wd.owner = pid_q;
        ram_wd.page = pg_q;
        ram_wd.load = t_q;
        ram_wd.last = t_q;
        ram_wd.cnt = TimeBits'(1);
      end
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  wire busy_out = ov_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      policy_q <= POL_MFU;
      frames_q <= 8'd100;
      ov_q <= 1'b0;
      idx_q <= '0;
      rd_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_POLICY) policy_q <= policy_e'(cfg_data_i[1:0]);
        else frames_q <= cfg_data_i;
      end
      if (ov_q && out_ready_i && state_q != S_OUT) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          op_q <= opcode_i; pid_q <= process_id_i; pg_q <= page_number_i;
          t_q <= tick_time_i; lim_q <= lim_d; idx_q <= '0; rd_v_q <= 1'b0;
          found_q <= 1'b0; free_q <= 1'b0; vic_q <= 1'b0; freed_q <= '0;
          hf_q <= '0; ff_q <= '0; vf_q <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN, S_LAST: begin
          if (rd_v_q && valid_q[rd_q]) begin
            if (ram_rd.owner == pid_q) begin
              if (op_q == OP_RELEASE) begin
                valid_q[rd_q] <= 1'b0;
                freed_q <= freed_q + 1'b1;
              end else begin
                if (!found_q && ram_rd.page == pg_q) begin
                  found_q <= 1'b1; hf_q <= rd_q; hit_e_q <= ram_rd;
                end
                if (!vic_q || better) begin
                  vic_q <= 1'b1; vf_q <= rd_q; vic_e_q <= ram_rd;
                end
              end
            end
          end else if (rd_v_q && !free_q) begin
            free_q <= 1'b1; ff_q <= rd_q;
          end
          if (state_q == S_SCAN) begin
            if (idx_q < lim_q) begin
              rd_q <= idx_q[AW-1:0]; rd_v_q <= 1'b1; idx_q <= idx_q + 1'b1;
            end else begin
              rd_v_q <= 1'b0;
            end
            if (idx_q >= lim_q) state_q <= S_LAST;
          end else begin
            state_q <= (op_q == OP_RELEASE) ? S_OUT : S_UPD;
          end
        end
        S_UPD: begin
          if (!upd_hit && (free_q || vic_q)) valid_q[fill_f] <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: if (!busy_out) begin
          ov_q <= 1'b1;
          o_fc_q <= CountOutBits'(freed_q);
          if (op_q == OP_RELEASE) begin
            o_hit_q <= 1'b0; o_fr_q <= '0; o_ev_q <= 1'b0; o_vp_q <= '0; o_nv_q <= 1'b0;
          end else begin
            o_hit_q <= found_q;
            o_ev_q <= !found_q && !free_q && vic_q;
            o_vp_q <= (!found_q && !free_q && vic_q) ? vic_e_q.page : '0;
            o_nv_q <= !found_q && !free_q && !vic_q;
            o_fr_q <= found_q ? FrameOutBits'(hf_q) :
                      (free_q || vic_q) ? FrameOutBits'(fill_f) : '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign hit_o = o_hit_q;
  assign frame_o = o_fr_q;
  assign evicted_o = o_ev_q;
  assign victim_page_o = o_vp_q;
  assign no_victim_o = o_nv_q;
  assign freed_count_o = o_fc_q;
endmodule
